### design/mm_pkg.sv
// Package: sizes, codes and shared types of the matrix multiply block.
package mm_pkg;

	localparam int MAX_DIM   = 8;
	localparam int ELEM_BITS = 16;
	localparam int SUM_BITS  = 35;
	localparam int IDX_BITS  = 3;
	localparam int DIM_BITS  = 4;
	localparam int ADDR_BITS = 2 * IDX_BITS;
	localparam int PROD_BITS = 2 * ELEM_BITS;
	localparam int CFG_IDX_BITS = 2;

	localparam logic [DIM_BITS-1:0] DIM_RESET = DIM_BITS'(MAX_DIM);

	typedef enum logic [1:0] {
		MODE_LOAD_A  = 2'd0,
		MODE_LOAD_B  = 2'd1,
		MODE_COMPUTE = 2'd2
	} mm_mode_t;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		CFG_ROWS_OF_A  = 2'd0,
		CFG_INNER_SIZE = 2'd1,
		CFG_COLS_OF_B  = 2'd2
	} mm_cfg_idx_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_DRAIN
	} mm_state_t;

	// Tags that travel with one multiply-accumulate through the pipe.
	typedef struct packed {
		logic [IDX_BITS-1:0] row;
		logic [IDX_BITS-1:0] col;
		logic                first;
		logic                last_k;
		logic                last_all;
	} mm_tag_t;

	// Register value to last index: zero acts as one, above MAX_DIM saturates.
	function automatic logic [IDX_BITS-1:0] dim_last(input logic [DIM_BITS-1:0] d);
		logic [IDX_BITS-1:0] r;
		if (d == '0)
			r = '0;
		else if (d > DIM_BITS'(MAX_DIM))
			r = IDX_BITS'(MAX_DIM - 1);
		else
			r = IDX_BITS'(d - DIM_BITS'(1));
		return r;
	endfunction

endpackage

### design/mm_if.sv
// Channel interfaces: load/compute items, result beats, configuration writes.
interface mm_in_if;
	import mm_pkg::*;
	logic                        valid;
	logic                        ready;
	logic [1:0]                  mode;
	logic [IDX_BITS-1:0]         row;
	logic [IDX_BITS-1:0]         col;
	logic signed [ELEM_BITS-1:0] value;
	modport source (output valid, mode, row, col, value, input ready);
	modport sink   (input valid, mode, row, col, value, output ready);
endinterface

interface mm_out_if;
	import mm_pkg::*;
	logic                       valid;
	logic                       ready;
	logic [IDX_BITS-1:0]        out_row;
	logic [IDX_BITS-1:0]        out_col;
	logic signed [SUM_BITS-1:0] sum;
	logic                       last;
	modport source (output valid, out_row, out_col, sum, last, input ready);
	modport sink   (input valid, out_row, out_col, sum, last, output ready);
endinterface

interface mm_cfg_if;
	import mm_pkg::*;
	logic                    valid;
	logic                    ready;
	logic [CFG_IDX_BITS-1:0] index;
	logic [DIM_BITS-1:0]     data;
	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

### design/matrix_multiply_top.sv
// Matrix multiply top level: element stores, MAC sequencer and result register.
// Load items (mode 0/1) are written straight into the stores; the block stays ready.
// A compute item runs rows*cols*inner multiply-accumulate steps through one MAC unit
// (one read of each store per cycle unless a result beat is stalled); ready returns
// once the pipe has drained after the last step, and results leave via the result register.
// Reset clears control and restores all dimensions to 8; store contents stay undefined.
module matrix_multiply_top
	import mm_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	mm_in_if.sink    items,
	mm_out_if.source results,
	mm_cfg_if.sink   cfg
);

	// configuration registers, always writable
	logic [DIM_BITS-1:0] rows_q, inner_q, cols_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q  <= DIM_RESET;
			inner_q <= DIM_RESET;
			cols_q  <= DIM_RESET;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				CFG_ROWS_OF_A:  rows_q  <= cfg.data;
				CFG_INNER_SIZE: inner_q <= cfg.data;
				CFG_COLS_OF_B:  cols_q  <= cfg.data;
				default: ;
			endcase
		end
	end

	// sequencer state
	mm_state_t state_q, state_d;
	logic [IDX_BITS-1:0] i_q, j_q, k_q;
	logic [IDX_BITS-1:0] ilast_q, jlast_q, klast_q;

	// pipe: s1 = store read data, s2 = product
	logic                        v_s1, v_s2;
	mm_tag_t                     tag_s1, tag_s2;
	logic signed [ELEM_BITS-1:0] rd_a_s1, rd_b_s1;
	logic signed [PROD_BITS-1:0] prod_s2;
	logic signed [SUM_BITS-1:0]  acc_q;

	// result register
	logic                       out_valid_q;
	logic [IDX_BITS-1:0]        out_row_q, out_col_q;
	logic signed [SUM_BITS-1:0] out_sum_q;
	logic                       out_last_q;

	logic    adv;       // whole pipe moves; holds while a result beat is stalled
	logic    issue;
	logic    start;
	logic    load_a, load_b;
	mm_tag_t tag_new;
	logic signed [SUM_BITS-1:0] prod_ext, acc_next;

	assign adv   = !out_valid_q || results.ready;
	assign issue = (state_q == ST_RUN) && adv;

	assign items.ready = (state_q == ST_IDLE);

	always_comb begin
		load_a = 1'b0;
		load_b = 1'b0;
		start  = 1'b0;
		if (items.valid && items.ready) begin
			unique case (items.mode)
				MODE_LOAD_A:  load_a = 1'b1;
				MODE_LOAD_B:  load_b = 1'b1;
				MODE_COMPUTE: start  = 1'b1;
				default: ;   // mode 3: no effect
			endcase
		end
	end

	always_comb begin
		tag_new.row      = i_q;
		tag_new.col      = j_q;
		tag_new.first    = (k_q == '0);
		tag_new.last_k   = (k_q == klast_q);
		tag_new.last_all = (k_q == klast_q) && (j_q == jlast_q) && (i_q == ilast_q);
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:  if (start) state_d = ST_RUN;
			ST_RUN:   if (issue && tag_new.last_all) state_d = ST_DRAIN;
			ST_DRAIN: if (!v_s1 && !v_s2) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	// loop counters: k innermost, then column, then row
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			i_q     <= '0;
			j_q     <= '0;
			k_q     <= '0;
			ilast_q <= '0;
			jlast_q <= '0;
			klast_q <= '0;
		end else if (start) begin
			i_q     <= '0;
			j_q     <= '0;
			k_q     <= '0;
			ilast_q <= dim_last(rows_q);
			jlast_q <= dim_last(cols_q);
			klast_q <= dim_last(inner_q);
		end else if (issue) begin
			if (k_q != klast_q) begin
				k_q <= k_q + IDX_BITS'(1);
			end else begin
				k_q <= '0;
				if (j_q != jlast_q) begin
					j_q <= j_q + IDX_BITS'(1);
				end else begin
					j_q <= '0;
					i_q <= i_q + IDX_BITS'(1);
				end
			end
		end
	end

	// element stores: one write port, one registered read each
	logic signed [ELEM_BITS-1:0] a_mem [MAX_DIM*MAX_DIM];
	logic signed [ELEM_BITS-1:0] b_mem [MAX_DIM*MAX_DIM];

	always_ff @(posedge clk) begin
		if (load_a)
			a_mem[{items.row, items.col}] <= items.value;
		if (load_b)
			b_mem[{items.row, items.col}] <= items.value;
		if (adv) begin
			rd_a_s1 <= a_mem[{i_q, k_q}];
			rd_b_s1 <= b_mem[{k_q, j_q}];
		end
	end

	// pipe valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s1 <= issue;
			v_s2 <= v_s1;
		end
	end

	// multiply stage
	always_ff @(posedge clk) begin
		if (adv) begin
			tag_s1  <= tag_new;
			tag_s2  <= tag_s1;
			prod_s2 <= rd_a_s1 * rd_b_s1;
		end
	end

	// accumulate: first term of each dot product restarts the sum
	assign prod_ext = SUM_BITS'(prod_s2);
	assign acc_next = tag_s2.first ? prod_ext : acc_q + prod_ext;

	always_ff @(posedge clk) begin
		if (adv && v_s2) begin
			acc_q <= acc_next;
			if (tag_s2.last_k) begin
				out_row_q  <= tag_s2.row;
				out_col_q  <= tag_s2.col;
				out_sum_q  <= acc_next;
				out_last_q <= tag_s2.last_all;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (adv && v_s2 && tag_s2.last_k)
			out_valid_q <= 1'b1;
		else if (results.ready)
			out_valid_q <= 1'b0;
	end

	assign results.valid   = out_valid_q;
	assign results.out_row = out_row_q;
	assign results.out_col = out_col_q;
	assign results.sum     = out_sum_q;
	assign results.last    = out_last_q;

	// checks
	a_idle_empty: assert property (@(posedge clk) disable iff (!arst_n)
		items.ready |-> (!v_s1 && !v_s2))
		else $error("ready while MACs in flight");

	a_last_implies_lastk: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 && tag_s2.last_all |-> tag_s2.last_k)
		else $error("final tag without end of dot product");

	a_result_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		adv && v_s2 && tag_s2.last_k |=> out_valid_q)
		else $error("finished dot product not presented");

	a_k_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_RUN |-> (k_q <= klast_q && j_q <= jlast_q && i_q <= ilast_q))
		else $error("loop counter past its bound");

	a_last_not_running: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid && results.last |-> !v_s2)
		else $error("last beat while a product is still in the pipe");

endmodule
